// ===== src/usr_pkg.sv =====
// ----------------------------------------------------------------------------
// usr_pkg: shared types and constants for the UTF-16 surrogate repair block
// Lane count, surrogate tags and the lane classification struct.
// ----------------------------------------------------------------------------
`default_nettype none

package usr_pkg;

    // Code units carried by one input beat
    localparam int LANES = 4;
    // Positions seen by the merge: the held unit plus one per lane
    localparam int POS   = LANES + 1;
    localparam int CNT_W = 3;
    localparam int UNIT_W = 16;

    localparam logic [UNIT_W-1:0] SURR_MASK = 16'hfc00;
    localparam logic [UNIT_W-1:0] HIGH_TAG  = 16'hd800;
    localparam logic [UNIT_W-1:0] LOW_TAG   = 16'hdc00;
    localparam logic [UNIT_W-1:0] REPL_LE   = 16'hfffd;
    localparam logic [UNIT_W-1:0] REPL_BE   = 16'hfdff;

    // Configuration register index (paddr[2])
    localparam logic REG_SWAP_MODE = 1'b0;

    typedef logic [UNIT_W-1:0] unit_t;

    typedef struct packed {
        logic high;
        logic low;
    } lane_cls_t;

    typedef struct packed {
        logic             held_valid;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } merge_ctrl_t;

    function automatic unit_t byte_swap(input unit_t u);
        byte_swap = {u[7:0], u[15:8]};
    endfunction

endpackage

`default_nettype wire

// ===== src/utf16_surrogate_repair.sv =====
// ----------------------------------------------------------------------------
// utf16_surrogate_repair: streaming repair of unpaired UTF-16 surrogates
// Replaces every unpaired high or low surrogate with U+FFFD, up to four units
// per beat, holding the newest unit back until its successor is known.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid / in_stall    | unit_0..3, unit_count,
//          |           |                        | end_of_text
//  out     | output    | out_valid / out_stall  | out_unit_0..4, out_count,
//          |           |                        | out_last
//  apb     | input     | psel / penable / pready| paddr, pwdata, prdata
//
//  One beat per cycle unless stalled; its result follows in the next cycle.
//  The only data loop is the held-unit register, updated in the accept cycle.
//  Input is taken while a result waits, unless that result is being stalled.
//  Reset (rst_n low, async) clears the held unit and the mode register.
//  Output payload holds steady while out_stall is high.
//
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_surrogate_repair
    import usr_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    // input beats
    input  wire        in_valid,
    output logic       in_stall,
    input  wire [15:0] unit_0,
    input  wire [15:0] unit_1,
    input  wire [15:0] unit_2,
    input  wire [15:0] unit_3,
    input  wire [2:0]  unit_count,
    input  wire        end_of_text,
    // result beats
    output logic       out_valid,
    input  wire        out_stall,
    output logic [15:0] out_unit_0,
    output logic [15:0] out_unit_1,
    output logic [15:0] out_unit_2,
    output logic [15:0] out_unit_3,
    output logic [15:0] out_unit_4,
    output logic [2:0] out_count,
    output logic       out_last,
    // configuration
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [2:0]  paddr,
    input  wire [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);

    logic             swap_mode_reg;
    unit_t            held_unit_reg;
    unit_t            held_unit_next;
    logic             held_valid_reg;
    logic             held_valid_next;
    logic             accept;
    logic [CNT_W-1:0] cnt;

    unit_t            lane_in   [LANES];
    unit_t            pos_unit  [POS];
    logic             pos_valid [POS];
    lane_cls_t        pos_cls   [POS];
    logic             pos_prev_high [POS];
    logic             pos_next_low  [POS];
    unit_t            pos_fix   [POS];
    unit_t            pos_low_fix [POS];
    unit_t            out_slot  [POS];
    merge_ctrl_t      ctrl;

    // ------------------------------------------------------------------
    // APB register: byte-order mode. Always ready.
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            swap_mode_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr[2] == REG_SWAP_MODE)
            swap_mode_reg <= pwdata[0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_SWAP_MODE)
            prdata[0] = swap_mode_reg;
    end

    // ------------------------------------------------------------------
    // Positions: 0 is the held unit, 1..LANES are this beat's units.
    // ------------------------------------------------------------------
    assign accept = in_valid && !in_stall;
    // a count above the lane width is clamped
    assign cnt = (unit_count > CNT_W'(LANES)) ? CNT_W'(LANES) : unit_count;

    assign lane_in[0] = unit_0;
    assign lane_in[1] = unit_1;
    assign lane_in[2] = unit_2;
    assign lane_in[3] = unit_3;

    assign pos_unit[0]  = held_unit_reg;
    assign pos_valid[0] = held_valid_reg;
    // the held unit already had its low-side repair; only its high side is open
    assign pos_prev_high[0] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_pos
            assign pos_unit[g+1]  = lane_in[g];
            assign pos_valid[g+1] = cnt > CNT_W'(g);
            // first lane looks back at the held unit, but only if one is held
            assign pos_prev_high[g+1] = pos_valid[g] && pos_cls[g].high;
        end

        for (g = 0; g < POS - 1; g++)
        begin : g_next
            assign pos_next_low[g] = pos_valid[g+1] && pos_cls[g+1].low;
        end

        for (g = 0; g < POS; g++)
        begin : g_lane
            usr_lane u_lane (
                .unit       (pos_unit[g]),
                .swapped    (swap_mode_reg),
                .prev_high  (pos_prev_high[g]),
                .next_low   (pos_next_low[g]),
                .cls        (pos_cls[g]),
                .fixed      (pos_fix[g]),
                .low_fixed  (pos_low_fix[g])
            );
        end
    endgenerate
    // the newest position has no successor: a high there is unpaired on flush
    assign pos_next_low[POS-1] = 1'b0;

    // ------------------------------------------------------------------
    // Held unit: newest unit of the beat, cleared on end of text.
    // ------------------------------------------------------------------
    always_comb
    begin
        held_unit_next  = held_unit_reg;
        held_valid_next = held_valid_reg;
        if (end_of_text)
        begin
            held_unit_next  = '0;
            held_valid_next = 1'b0;
        end
        else if (cnt != '0)
        begin
            held_unit_next  = pos_low_fix[cnt];
            held_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_unit_reg  <= '0;
            held_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_unit_reg  <= held_unit_next;
            held_valid_reg <= held_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Merge and output register
    // ------------------------------------------------------------------
    assign ctrl.held_valid = held_valid_reg;
    assign ctrl.cnt        = cnt;
    assign ctrl.last       = end_of_text;

    usr_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .ctrl      (ctrl),
        .pos_fix   (pos_fix),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .in_stall  (in_stall),
        .out_slot  (out_slot),
        .out_count (out_count),
        .out_last  (out_last)
    );

    assign out_unit_0 = out_slot[0];
    assign out_unit_1 = out_slot[1];
    assign out_unit_2 = out_slot[2];
    assign out_unit_3 = out_slot[3];
    assign out_unit_4 = out_slot[4];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_text) |=> !held_valid_reg)
        else $error("held unit survived end of text");

    a_units_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !end_of_text && unit_count != 3'd0) |=> held_valid_reg)
        else $error("non-empty beat left nothing held");

    a_idle_held_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !held_valid_reg |-> held_unit_reg == '0)
        else $error("held unit not zero while nothing is held");

    a_mid_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |-> out_count <= CNT_W'(LANES))
        else $error("non-final beat releases more than one lane width");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (out_valid && out_last == $past(end_of_text)))
        else $error("accepted beat did not reach the output register");

endmodule

`default_nettype wire

// ===== src/usr_lane.sv =====
// ----------------------------------------------------------------------------
// usr_lane: per-unit surrogate classification and repair
// Classifies one code unit and replaces it when its neighbours leave it unpaired.
// ----------------------------------------------------------------------------
`default_nettype none

module usr_lane
    import usr_pkg::*;
(
    input  wire unit_t     unit,
    input  wire            swapped,
    input  wire            prev_high,   // predecessor is a high surrogate
    input  wire            next_low,    // successor present and a low surrogate
    output lane_cls_t      cls,
    output unit_t          fixed,       // fully repaired, for release
    output unit_t          low_fixed    // low-side repair only, for holding
);

    unit_t native;
    unit_t repl;
    logic  bad_low;
    logic  bad_high;

    always_comb
    begin
        native   = swapped ? byte_swap(unit) : unit;
        repl     = swapped ? REPL_BE : REPL_LE;
        cls.high = (native & SURR_MASK) == HIGH_TAG;
        cls.low  = (native & SURR_MASK) == LOW_TAG;
        bad_low  = cls.low && !prev_high;
        bad_high = cls.high && !next_low;
        low_fixed = bad_low ? repl : unit;
        fixed     = (bad_low || bad_high) ? repl : unit;
    end

endmodule

`default_nettype wire

// ===== src/usr_merge.sv =====
// ----------------------------------------------------------------------------
// usr_merge: compaction and output register
// Packs released positions into the low slots, counts them and registers the beat.
// ----------------------------------------------------------------------------
`default_nettype none

module usr_merge
    import usr_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              load,
    input  wire merge_ctrl_t ctrl,
    input  wire unit_t       pos_fix [POS],
    input  wire              out_stall,
    output logic             out_valid,
    output logic             in_stall,
    output unit_t            out_slot [POS],
    output logic [CNT_W-1:0] out_count,
    output logic             out_last
);

    unit_t            shifted [POS];
    unit_t            slot_next [POS];
    logic [CNT_W-1:0] nvalid;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    unit_t            slot_reg [POS];
    logic [CNT_W-1:0] count_reg;
    logic             last_reg;

    // Without a held unit, the first lane moves up into slot 0
    genvar g;
    generate
        for (g = 0; g < POS - 1; g++)
        begin : g_shift
            assign shifted[g] = pos_fix[g+1];
        end
    endgenerate
    assign shifted[POS-1] = '0;

    always_comb
    begin
        nvalid = {{(CNT_W-1){1'b0}}, ctrl.held_valid} + ctrl.cnt;
        if (ctrl.last)
            count_next = nvalid;
        else if (nvalid == '0)
            count_next = '0;
        else
            count_next = nvalid - CNT_W'(1);
        for (int j = 0; j < POS; j++)
        begin
            if (CNT_W'(j) < count_next)
                slot_next[j] = ctrl.held_valid ? pos_fix[j] : shifted[j];
            else
                slot_next[j] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg  <= slot_next;
            count_reg <= count_next;
            last_reg  <= ctrl.last;
        end
    end

    assign in_stall  = out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign out_slot  = slot_reg;
    assign out_count = count_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for utf16_surrogate_repair
// Drives UTF-16 beats in both byte orders through the valid/stall input,
// predicts every result beat with a local shadow of the held unit, and
// checks each released beat field by field, in order, under random idling
// on both sides and two long output hold-offs.
// ----------------------------------------------------------------------------

module tb_top
    import usr_pkg::*;
();

    // Cycles with no beat, no register access, before the run is abandoned.
    // Worst honest stall is a full output hold-off plus a random stall burst.
    localparam int QUIET_LIMIT = 600;
    localparam int HOLD_CYCLES = 60;
    localparam int PRINT_CAP   = 40;

    // One input beat as the block sees it; lane 0 is the oldest unit
    typedef struct packed {
        logic [LANES-1:0][UNIT_W-1:0] u;
        logic [CNT_W-1:0]             cnt;
        logic                         eot;
    } text_beat_t;

    // One result beat; slots above cnt must read as zero
    typedef struct packed {
        logic [POS-1:0][UNIT_W-1:0] u;
        logic [CNT_W-1:0]           cnt;
        logic                       last;
    } repaired_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] unit_0 = '0;
    logic [15:0] unit_1 = '0;
    logic [15:0] unit_2 = '0;
    logic [15:0] unit_3 = '0;
    logic [2:0]  unit_count = '0;
    logic        end_of_text = 1'b0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] out_unit_0;
    logic [15:0] out_unit_1;
    logic [15:0] out_unit_2;
    logic [15:0] out_unit_3;
    logic [15:0] out_unit_4;
    logic [2:0]  out_count;
    logic        out_last;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    utf16_surrogate_repair dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .unit_0      (unit_0),
        .unit_1      (unit_1),
        .unit_2      (unit_2),
        .unit_3      (unit_3),
        .unit_count  (unit_count),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_unit_0  (out_unit_0),
        .out_unit_1  (out_unit_1),
        .out_unit_2  (out_unit_2),
        .out_unit_3  (out_unit_3),
        .out_unit_4  (out_unit_4),
        .out_count   (out_count),
        .out_last    (out_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 12 ns period
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------------
    // Shadow of the block: held unit, its valid flag and the byte order.
    // The held unit is kept in wire order with any lone-low repair already
    // applied; a held high surrogate is still undecided.
    // ------------------------------------------------------------------------
    unit_t shadow_held = '0;
    logic  shadow_held_ok = 1'b0;
    logic  shadow_be = 1'b0;

    function automatic unit_t swap_if(input logic sw, input unit_t u);
        return sw ? {u[7:0], u[15:8]} : u;
    endfunction

    function automatic logic high_surr(input unit_t u);
        return (swap_if(shadow_be, u) & SURR_MASK) == HIGH_TAG;
    endfunction

    function automatic logic low_surr(input unit_t u);
        return (swap_if(shadow_be, u) & SURR_MASK) == LOW_TAG;
    endfunction

    // Advances the shadow by one accepted beat and returns what it releases
    function automatic repaired_t repair_beat(input text_beat_t b);
        repaired_t r;
        unit_t     fffd;
        unit_t     u;
        logic      paired;
        int        n;
        int        k;
        r    = '0;
        k    = 0;
        fffd = shadow_be ? REPL_BE : REPL_LE;
        // counts above the lane width fold back to a full beat
        n    = (b.cnt > LANES) ? LANES : int'(b.cnt);
        for (int i = 0; i < n; i++)
        begin
            u      = b.u[i];
            paired = 1'b0;
            if (shadow_held_ok)
            begin
                // the incoming unit decides the fate of the held one
                paired = high_surr(shadow_held);
                r.u[k] = (paired && !low_surr(u)) ? fffd : shadow_held;
                k++;
            end
            // a low with no high in front of it, including at stream start
            if (low_surr(u) && !paired)
                u = fffd;
            shadow_held    = u;
            shadow_held_ok = 1'b1;
        end
        if (b.eot)
        begin
            // flush: a high left dangling at the end is unpaired
            if (shadow_held_ok)
            begin
                r.u[k] = high_surr(shadow_held) ? fffd : shadow_held;
                k++;
            end
            shadow_held    = '0;
            shadow_held_ok = 1'b0;
        end
        r.cnt  = CNT_W'(k);
        r.last = b.eot;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus store and text generator
    // ------------------------------------------------------------------------
    text_beat_t pending_beats[$];
    repaired_t  expected_beats[$];
    int         queued = 0;
    int         beats_in = 0;
    int         mismatches = 0;
    int         idle_pct = 0;     // chance per free cycle of starting a burst

    logic       text_be = 1'b0;   // byte order the generator writes in
    logic       text_need_low = 1'b0;

    // Mostly well-formed text: highs are followed by lows, with a few
    // dropped lows, lone lows and raw noise mixed in.
    function automatic unit_t next_text_unit();
        int    pick;
        unit_t u;
        pick = $urandom_range(99);
        if (text_need_low && pick >= 8)
        begin
            u = LOW_TAG | unit_t'($urandom_range(1023));
            text_need_low = 1'b0;
        end
        else if (pick < 25 && pick >= 8)
        begin
            u = HIGH_TAG | unit_t'($urandom_range(1023));
            text_need_low = 1'b1;
        end
        else
        begin
            text_need_low = 1'b0;
            if (pick < 4)
                u = unit_t'($urandom);
            else if (pick < 8)
                u = LOW_TAG | unit_t'($urandom_range(1023));
            else if (pick < 30)
                u = pick[0] ? 16'hffff : 16'h0000;
            else if (pick < 60)
                u = unit_t'($urandom_range(16'hffff, 16'he000));
            else
                u = unit_t'($urandom_range(16'hd7ff));
        end
        return swap_if(text_be, u);
    endfunction

    task automatic push_beat(input unit_t a, input unit_t b, input unit_t c,
                             input unit_t d, input logic [2:0] n, input logic e);
        text_beat_t t;
        t.u   = {d, c, b, a};
        t.cnt = n;
        t.eot = e;
        pending_beats.push_back(t);
        queued++;
    endtask

    task automatic queue_random(input int n);
        text_beat_t b;
        int         c;
        for (int i = 0; i < n; i++)
        begin
            c = $urandom_range(99);
            if (c < 5)
                b.cnt = '0;
            else if (c < 10)
                b.cnt = CNT_W'($urandom_range(7, 5));
            else
                b.cnt = CNT_W'($urandom_range(4, 1));
            // lanes past the count carry junk the block must ignore
            for (int j = 0; j < LANES; j++)
                b.u[j] = (j < b.cnt) ? next_text_unit() : unit_t'($urandom);
            b.eot = ($urandom_range(99) < 3) || (i == n - 1);
            if (b.eot)
                text_need_low = 1'b0;
            pending_beats.push_back(b);
            queued++;
        end
    endtask

    // Wait until every queued beat is in and every result is out
    task automatic drain();
        while (beats_in != queued)
            @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t ns %s: got %h, want %h", $time, what, got, want);
    endtask

    // APB write of the byte-order register, then a read back
    task automatic set_byte_order(input logic be);
        logic [31:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(REG_SWAP_MODE) << 2;
        pwdata  <= 32'(be);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        shadow_be = be;
        text_be   = be;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== 32'(be))
            report("byte order read back", rd, 32'(be));
    endtask

    // ------------------------------------------------------------------------
    // Input driver: offers the next beat at the falling edge once the
    // previous one has been taken. Idle bursts are chosen without looking
    // at in_stall, and an offered beat is held until accepted.
    // ------------------------------------------------------------------------
    logic       in_took = 1'b0;
    int         tx_gap = 0;
    text_beat_t tx_beat;

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() != 0 && idle_pct != 0 &&
                     $urandom_range(99) < idle_pct)
            begin
                tx_gap = $urandom_range(12);
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                tx_beat = pending_beats.pop_front();
                unit_0      <= tx_beat.u[0];
                unit_1      <= tx_beat.u[1];
                unit_2      <= tx_beat.u[2];
                unit_3      <= tx_beat.u[3];
                unit_count  <= tx_beat.cnt;
                end_of_text <= tx_beat.eot;
                in_valid    <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Output side: random stall bursts, plus two long hold-offs while the
    // sender keeps offering, so the block backs up and stalls its input.
    // ------------------------------------------------------------------------
    int rx_gap = 0;
    int hold_left = 0;
    int holds_done = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (holds_done < 2 && beats_in >= (holds_done == 0 ? 300 : 800))
            begin
                hold_left = HOLD_CYCLES - 1;
                holds_done++;
                out_stall <= 1'b1;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                out_stall <= 1'b1;
            end
            else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            begin
                rx_gap = $urandom_range(12);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and scoreboard, sampled at the rising edge. The result check
    // runs before the prediction: results come from a register, so a result
    // taken on this edge never belongs to the beat taken on the same edge.
    // ------------------------------------------------------------------------
    int        quiet = 0;
    logic      out_took;
    repaired_t got_beat;
    repaired_t want_beat;
    text_beat_t seen_beat;

    always @(posedge clk)
    begin
        in_took  = in_valid && !in_stall;
        out_took = out_valid && !out_stall;
        if (rst_n)
        begin
            if (out_took)
            begin
                got_beat.u    = {out_unit_4, out_unit_3, out_unit_2, out_unit_1,
                                 out_unit_0};
                got_beat.cnt  = out_count;
                got_beat.last = out_last;
                if (expected_beats.size() == 0)
                    report("result beat with nothing expected", 32'(got_beat.cnt), 0);
                else
                begin
                    want_beat = expected_beats.pop_front();
                    for (int k = 0; k < POS; k++)
                        if (got_beat.u[k] !== want_beat.u[k])
                            report($sformatf("out_unit_%0d", k), 32'(got_beat.u[k]),
                                   32'(want_beat.u[k]));
                    if (got_beat.cnt !== want_beat.cnt)
                        report("out_count", 32'(got_beat.cnt), 32'(want_beat.cnt));
                    if (got_beat.last !== want_beat.last)
                        report("out_last", 32'(got_beat.last), 32'(want_beat.last));
                end
            end
            if (in_took)
            begin
                seen_beat.u   = {unit_3, unit_2, unit_1, unit_0};
                seen_beat.cnt = unit_count;
                seen_beat.eot = end_of_text;
                expected_beats.push_back(repair_beat(seen_beat));
                beats_in++;
            end
            // watchdog: any beat or register access counts as progress
            if (in_took || out_took || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // native order, directed corner cases
        set_byte_order(1'b0);
        idle_pct = 20;
        push_beat(16'hdc00, 16'h0041, 16'h1234, 16'h5678, 3'd2, 1'b0); // low at stream start
        push_beat(16'h0000, 16'hd800, 16'hdc00, 16'hffff, 3'd4, 1'b0); // extremes, pair in beat
        push_beat(16'hd800, 16'hffff, 16'hffff, 16'hffff, 3'd1, 1'b0); // high left held
        push_beat(16'hdfff, 16'h0000, 16'h0000, 16'h0000, 3'd1, 1'b0); // low pairs across beats
        push_beat(16'hdbff, 16'hdbff, 16'hdc00, 16'h0041, 3'd4, 1'b0); // high then high
        push_beat(16'h0041, 16'hdc00, 16'hd800, 16'hd800, 3'd2, 1'b0); // lone low mid-text
        push_beat(16'hd800, 16'hdc00, 16'hffff, 16'haaaa, 3'd0, 1'b0); // empty, unit held
        push_beat(16'hd800, 16'hffff, 16'hdfff, 16'h5555, 3'd7, 1'b0); // count above lanes
        push_beat(16'hdbff, 16'h0000, 16'h0000, 16'h0000, 3'd1, 1'b1); // high at end of text
        push_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd0, 1'b1); // empty end, none held
        push_beat(16'hdc00, 16'hd800, 16'hd800, 16'hd800, 3'd1, 1'b1); // low alone, start and end
        push_beat(16'habcd, 16'hd800, 16'h0000, 16'h0000, 3'd2, 1'b1); // trailing high flushed
        push_beat(16'hffff, 16'hffff, 16'hffff, 16'hffff, 3'd4, 1'b1);
        drain();

        // byte-swapped order, directed
        set_byte_order(1'b1);
        push_beat(16'h00dc, 16'h00d8, 16'h00dc, 16'hffff, 3'd4, 1'b0); // low at start, pair
        push_beat(16'h00d8, 16'h0000, 16'h0000, 16'h0000, 3'd1, 1'b0);
        push_beat(16'h00d8, 16'h4100, 16'h0000, 16'h0000, 3'd2, 1'b0); // high, high, plain
        push_beat(16'hfffd, 16'h00dc, 16'hd800, 16'hdc00, 3'd5, 1'b0); // native tags are plain
        push_beat(16'hffdb, 16'h0000, 16'h0000, 16'h0000, 3'd1, 1'b1); // high at end
        push_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd0, 1'b1);
        drain();

        // random text; first long hold-off falls in this phase
        idle_pct = 30;
        queue_random(300);
        drain();

        // a stretch with no idling at all
        set_byte_order(1'b0);
        idle_pct = 0;
        queue_random(350);
        drain();

        // second hold-off falls here
        set_byte_order(1'b1);
        idle_pct = 10;
        queue_random(350);
        drain();

        // closing part at full rate, no idling on either side
        set_byte_order(1'b0);
        idle_pct = 0;
        queue_random(350);
        drain();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
